FILE: hw/rtl/sat_pkg.sv
package sat_pkg;

	localparam int DEF_MAX_SECTIONS = 16;
	localparam int ADDR_W           = 32;
	localparam int ENTRY_IDX_W      = 4;
	localparam int COUNT_W          = 5;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_V2F   = 2'd1;
	localparam logic [1:0] OP_F2V   = 2'd2;

	typedef struct packed {
		logic [1:0]             operation;
		logic [ENTRY_IDX_W-1:0] entry_index;
		logic [ADDR_W-1:0]      virt_base;
		logic [ADDR_W-1:0]      virt_length;
		logic [ADDR_W-1:0]      raw_base;
		logic [ADDR_W-1:0]      raw_length;
		logic [ADDR_W-1:0]      query_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] translated_address;
		logic              out_of_range;
		logic              section_hit;
	} rsp_t;

	typedef logic [COUNT_W-1:0] cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] virt_base;
		logic [ADDR_W-1:0] virt_length;
		logic [ADDR_W-1:0] raw_base;
		logic [ADDR_W-1:0] raw_length;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN
	} state_t;

	typedef enum logic [1:0] {
		RES_OOR,
		RES_HIT,
		RES_PASS
	} res_kind_t;

	typedef struct packed {
		logic      capture;
		logic      wr_en;
		logic      rd_en;
		logic      load;
		res_kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic above;
		logic out_busy;
	} status_t;

endpackage

FILE: hw/rtl/sat_stream_if.sv
interface sat_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/section_address_translator_core.sv
// Channel | Dir | Beat payload                                    | Accepted when
// --------+-----+-------------------------------------------------+--------------------
// req     | in  | operation, entry_index, section fields, address | req.valid & req.ready
// rsp     | out | translated_address, out_of_range, section_hit   | rsp.valid & rsp.ready
// cfg     | in  | section_count                                   | cfg.valid & cfg.ready
//
// Write beat: written to the table on accept, no result. Translate beat: the
// last entry is fetched first for the end-of-image check, then entries are
// scanned in order through the table's single read port, at most the section
// count of them. Reset clears the section count and control; table contents
// stay undefined until written, with no clearing pass. A finished result
// waits in the output register while the next beat is taken.
module section_address_translator_core #(
	parameter int MAX_SECTIONS = sat_pkg::DEF_MAX_SECTIONS
) (
	input  logic         clk,
	input  logic         arst_n,
	sat_stream_if.sink   req,
	sat_stream_if.source rsp,
	sat_stream_if.sink   cfg
);
	import sat_pkg::*;

	// table index width; one bit minimum for a single-entry table
	localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

	cmd_t          cmd;
	status_t       status;
	logic [IW-1:0] rd_idx;

	// sequencer: accept, end-of-image check, in-order scan, result load
	sat_ctrl #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.IW           (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_op    (req.data.operation),
		.req_idx   (req.data.entry_index),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cfg_data  (cfg.data),
		.status    (status),
		.cmd       (cmd),
		.rd_idx    (rd_idx)
	);

	// section table memory, range compare, rebase adder, output register
	sat_dp #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.IW           (IW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.status   (status),
		.rsp      (rsp)
	);

endmodule

FILE: hw/rtl/sat_ctrl.sv
module sat_ctrl #(
	parameter int MAX_SECTIONS = sat_pkg::DEF_MAX_SECTIONS,
	parameter int IW           = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [1:0]                       req_op,
	input  logic [sat_pkg::ENTRY_IDX_W-1:0]  req_idx,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  sat_pkg::cfg_t                    cfg_data,
	input  sat_pkg::status_t                 status,
	output sat_pkg::cmd_t                    cmd,
	output logic [IW-1:0]                    rd_idx
);
	import sat_pkg::*;

	localparam int NW = $clog2(MAX_SECTIONS + 1);

	state_t          state_q, state_nx;
	cfg_t            count_q;
	logic [IW-1:0]   cur_q;
	logic [NW-1:0]   n_c;
	logic [IW-1:0]   last_idx;
	logic            accept;
	logic            is_xlate;

	// number of live entries, clamped to the table depth
	assign n_c      = (32'(count_q) > MAX_SECTIONS) ? NW'(MAX_SECTIONS) : NW'(count_q);
	assign last_idx = IW'(n_c - NW'(1));
	// ready is high exactly in idle
	assign accept   = req_valid && (state_q == ST_IDLE);
	assign is_xlate = (req_op == OP_V2F) || (req_op == OP_F2V);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
		end
	end

	// index of the entry now sitting in the read register
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			cur_q <= rd_idx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_xlate) begin
					state_nx = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (n_c == '0 || status.above) begin
					if (!status.out_busy) begin
						state_nx = ST_IDLE;
					end
				end else begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.hit || cur_q == last_idx) begin
					if (!status.out_busy) begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.wr_en   = 1'b0;
		cmd.rd_en   = 1'b0;
		cmd.load    = 1'b0;
		cmd.kind    = RES_PASS;
		rd_idx      = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = accept;
				cmd.wr_en   = accept && (req_op == OP_WRITE) && (32'(req_idx) < MAX_SECTIONS);
				// fetch the last entry for the end-of-image check
				cmd.rd_en   = accept && is_xlate && (n_c != '0);
				rd_idx      = last_idx;
			end
			ST_CHECK: begin
				if (n_c == '0 || status.above) begin
					cmd.kind = RES_OOR;
					cmd.load = !status.out_busy;
				end else begin
					cmd.rd_en = 1'b1;
					rd_idx    = '0;
				end
			end
			ST_SCAN: begin
				if (status.hit) begin
					cmd.kind = RES_HIT;
					cmd.load = !status.out_busy;
				end else if (cur_q == last_idx) begin
					cmd.kind = RES_PASS;
					cmd.load = !status.out_busy;
				end else begin
					cmd.rd_en = 1'b1;
					rd_idx    = cur_q + IW'(1);
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/sat_dp.sv
module sat_dp #(
	parameter int MAX_SECTIONS = sat_pkg::DEF_MAX_SECTIONS,
	parameter int IW           = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sat_pkg::req_t     req_data,
	input  sat_pkg::cmd_t     cmd,
	input  logic [IW-1:0]     rd_idx,
	output sat_pkg::status_t  status,
	sat_stream_if.source      rsp
);
	import sat_pkg::*;

	entry_t              mem_q [MAX_SECTIONS];
	entry_t              rd_data_s1;
	logic [1:0]          op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [ADDR_W-1:0]   lo;
	logic [ADDR_W-1:0]   len;
	logic [ADDR_W-1:0]   to_base;
	logic [ADDR_W:0]     hi;
	logic [ADDR_W-1:0]   rebased;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[IW'(req_data.entry_index)] <= '{
				virt_base:   req_data.virt_base,
				virt_length: req_data.virt_length,
				raw_base:    req_data.raw_base,
				raw_length:  req_data.raw_length
			};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[rd_idx];
		end
		if (cmd.capture) begin
			op_q   <= req_data.operation;
			addr_q <= req_data.query_address;
		end
	end

	// pick source / destination space by direction
	always_comb begin
		if (op_q == OP_V2F) begin
			lo      = rd_data_s1.virt_base;
			len     = rd_data_s1.virt_length;
			to_base = rd_data_s1.raw_base;
		end else begin
			lo      = rd_data_s1.raw_base;
			len     = rd_data_s1.raw_length;
			to_base = rd_data_s1.virt_base;
		end
	end

	assign hi      = {1'b0, lo} + {1'b0, len};
	assign rebased = to_base + (addr_q - lo);

	assign status.above    = {1'b0, addr_q} > hi;
	assign status.hit      = (addr_q >= lo) && ({1'b0, addr_q} < hi);
	assign status.out_busy = rsp_valid_q && !rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cmd.kind)
				RES_OOR: begin
					rsp_q.translated_address <= '1;
					rsp_q.out_of_range       <= 1'b1;
					rsp_q.section_hit        <= 1'b0;
				end
				RES_HIT: begin
					rsp_q.translated_address <= rebased;
					rsp_q.out_of_range       <= 1'b0;
					rsp_q.section_hit        <= 1'b1;
				end
				default: begin
					rsp_q.translated_address <= addr_q;
					rsp_q.out_of_range       <= 1'b0;
					rsp_q.section_hit        <= 1'b0;
				end
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule
